FILE: hw/rtl/cht_pkg.sv
`default_nettype none
package cht_pkg;

   localparam int CHT_ENTRIES = 64;

   localparam logic [31:0] REFILL_RESET     = 32'd7200;
   localparam logic [31:0] HYSTERESIS_RESET = 32'd60;
   localparam logic [31:0] REENABLE_RESET   = 32'd60;

   localparam logic [1:0] REG_REFILL     = 2'd0;
   localparam logic [1:0] REG_HYSTERESIS = 2'd1;
   localparam logic [1:0] REG_REENABLE   = 2'd2;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_REFILL = 2'd2;

   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_REPLACED = 3'd1;
   localparam logic [2:0] ST_STALE    = 3'd2;
   localparam logic [2:0] ST_FOUND    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;
   localparam logic [2:0] ST_REFILLED = 3'd6;

   localparam int DIV_BITS = 96;

   typedef struct packed {
      logic [63:0] channel;
      logic        direction;
      logic [31:0] time_sec;
      logic        enabled;
      logic [63:0] estimate;
      logic [63:0] capacity;
   } entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        enabled;
      logic [63:0] estimate;
      logic [63:0] capacity;
      logic [31:0] time_sec;
   } result_type;

endpackage
`default_nettype wire

FILE: hw/rtl/cht_store.sv
`default_nettype none
module cht_store
   import cht_pkg::*;
#(
   parameter int ENTRIES = CHT_ENTRIES
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  wire entry_type                  wr_data,
   input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
   output entry_type                       rd_data
);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/cht_divider.sv
`default_nettype none
module cht_divider
   import cht_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DIV_BITS-1:0] dividend,
   input  wire logic [31:0]         divisor,
   output logic                     done,
   output logic [DIV_BITS-1:0]      quotient
);

   localparam int CW = $clog2(DIV_BITS + 1);

   logic [DIV_BITS-1:0] q_ff, q_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         div_ff;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [32:0]         trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[DIV_BITS-1]};
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 32'(trial - {1'b0, div_ff});
            q_in   = {q_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/capacity_hint_table.sv
// Add and find scan the stored entries in order until a key matches or the
// fill count is reached. Refill scans every stored entry; each entry that is
// refilled takes two 32x32 products and a 96-step bit-serial divide.
// Throughput: one request at a time; ready only while the sequencer idles.
// Reset clears the fill count, the sequencer and the response valid and
// loads the register reset values; the entry memory needs no clearing.
`default_nettype none
module capacity_hint_table
   import cht_pkg::*;
#(
   parameter int TABLE_ENTRIES = CHT_ENTRIES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [63:0] channel_id, [64] direction, [96:65] time_sec, [97] enable_flag,
   // [98] has_estimate, [162:99] estimate_msat, [226:163] capacity_msat
   input  wire logic [231:0] req_tdata,
   // [1:0] op
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [0] hint_enabled, [64:1] hint_estimate_msat, [128:65] hint_capacity_msat,
   // [160:129] hint_time_sec
   output logic [167:0]      rsp_tdata,
   // [2:0] status
   output logic [2:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_MUL1 = 3'd3;
   localparam logic [2:0] S_MUL2 = 3'd4;
   localparam logic [2:0] S_DIVS = 3'd5;
   localparam logic [2:0] S_DIVW = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in, count_ff, count_in;
   logic [31:0] refill_ff, hyst_ff, reen_ff;

   logic [1:0]  op_ff;
   logic [63:0] chan_ff, est_ff, cap_ff;
   logic        dir_ff, en_ff, has_ff;
   logic [31:0] tm_ff;

   entry_type  ent_ff, ent_in, rd_data, wr_data;
   logic       wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   result_type res_ff, res_in, out_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [31:0] secs_ff, secs_in;
   logic [63:0] lo_ff, hi_ff;
   logic        div_start, div_done;
   logic [DIV_BITS-1:0] quot;
   logic [32:0] ready_at;
   logic [64:0] sum;
   logic        key_hit;

   cht_store #(.ENTRIES(TABLE_ENTRIES)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   cht_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend({hi_ff, 32'd0} + {32'd0, lo_ff}),
      .divisor ((refill_ff == 32'd0) ? 32'd1 : refill_ff),
      .done    (div_done),
      .quotient(quot)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      ent_in       = ent_ff;
      res_in       = res_ff;
      secs_in      = secs_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = ent_ff;
      rd_addr      = idx_ff[AW-1:0];
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ready_at     = {1'b0, rd_data.time_sec} + {1'b0, hyst_ff};
      key_hit      = (rd_data.channel == chan_ff) && (rd_data.direction == dir_ff)
                     && (op_ff == OP_ADD || op_ff == OP_FIND);
      sum          = {1'b0, ent_ff.estimate} + {1'b0, quot[63:0]};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == count_ff) begin
               res_in   = '0;
               state_in = S_DONE;
               if (op_ff == OP_ADD) begin
                  if (count_ff == CW'(TABLE_ENTRIES)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     // append into the first free slot
                     wr_en             = 1'b1;
                     wr_addr           = count_ff[AW-1:0];
                     wr_data.channel   = chan_ff;
                     wr_data.direction = dir_ff;
                     wr_data.time_sec  = tm_ff;
                     wr_data.enabled   = en_ff;
                     wr_data.capacity  = cap_ff;
                     wr_data.estimate  = has_ff ? est_ff : cap_ff;
                     count_in          = count_ff + 1'b1;
                     res_in            = '{ST_ADDED, en_ff, wr_data.estimate,
                                           cap_ff, tm_ff};
                  end
               end else if (op_ff == OP_REFILL) begin
                  res_in.status = ST_REFILLED;
               end else begin
                  res_in.status = ST_NOTFOUND;
               end
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            ent_in = rd_data;
            if (op_ff == OP_REFILL) begin
               if ({1'b0, tm_ff} < ready_at) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SCAN;
               end else begin
                  secs_in  = tm_ff - rd_data.time_sec;
                  state_in = S_MUL1;
               end
            end else if (key_hit) begin
               state_in = S_DONE;
               res_in   = '{ST_FOUND, rd_data.enabled, rd_data.estimate,
                            rd_data.capacity, rd_data.time_sec};
               if (op_ff == OP_ADD) begin
                  if (rd_data.time_sec <= tm_ff) begin
                     res_in.status    = ST_REPLACED;
                     wr_en            = 1'b1;
                     wr_data          = rd_data;
                     wr_data.enabled  = en_ff;
                     wr_data.time_sec = tm_ff;
                     if (has_ff) begin
                        wr_data.estimate = est_ff;
                     end
                     if (cap_ff > rd_data.capacity) begin
                        wr_data.capacity = cap_ff;
                     end
                  end else begin
                     res_in = '0;
                     res_in.status = ST_STALE;
                  end
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_DIVS;
         S_DIVS: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               wr_en   = 1'b1;
               wr_data = ent_ff;
               if (quot[DIV_BITS-1:64] != '0 || sum[64] || sum[63:0] > ent_ff.capacity) begin
                  wr_data.estimate = ent_ff.capacity;
               end else begin
                  wr_data.estimate = sum[63:0];
               end
               if (secs_ff > reen_ff) begin
                  wr_data.enabled = 1'b1;
               end
               wr_data.time_sec = tm_ff;
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         refill_ff    <= REFILL_RESET;
         hyst_ff      <= HYSTERESIS_RESET;
         reen_ff      <= REENABLE_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_REFILL:     refill_ff <= csr_data;
               REG_HYSTERESIS: hyst_ff   <= csr_data;
               REG_REENABLE:   reen_ff   <= csr_data;
               default: ;
            endcase
         end
      end
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tuser;
         chan_ff <= req_tdata[63:0];
         dir_ff  <= req_tdata[64];
         tm_ff   <= req_tdata[96:65];
         en_ff   <= req_tdata[97];
         has_ff  <= req_tdata[98];
         est_ff  <= req_tdata[162:99];
         cap_ff  <= req_tdata[226:163];
      end
      ent_ff  <= ent_in;
      res_ff  <= res_in;
      secs_ff <= secs_in;
      if (state_ff == S_MUL1) begin
         lo_ff <= ent_ff.capacity[31:0] * secs_ff;
      end
      if (state_ff == S_MUL2) begin
         hi_ff <= ent_ff.capacity[63:32] * secs_ff;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {7'd0, out_ff.time_sec, out_ff.capacity, out_ff.estimate,
                        out_ff.enabled};

endmodule
`default_nettype wire

FILE: hw/rtl/cht_checker.sv
`default_nettype none
module cht_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [167:0] rsp_tdata,
   input wire logic [2:0]   rsp_tuser
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 3'd7))
      else $error("bad status code");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind capacity_hint_table cht_checker u_cht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
`default_nettype wire
